>>> rtl/core/mesh_bilinear_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mesh bilinear interpolator
// Implication checks clocked on the rising edge and idle during reset.
// ----------------------------------------------------------------------------
`ifndef MESH_BILINEAR_INTERPOLATOR_ASSERT_SVH
`define MESH_BILINEAR_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication.
`define MBI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mbi assertion failed in %m");

// Next-cycle implication.
`define MBI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mbi assertion failed in %m");

`endif

>>> rtl/core/mbi_pkg.sv
// ----------------------------------------------------------------------------
// mbi_pkg
// Status codes, mask codes and the sideband record shared by the interpolator.
// ----------------------------------------------------------------------------
package mbi_pkg;

    typedef enum logic [2:0] {
        ST_BILINEAR  = 3'd0,
        ST_Y_ONLY    = 3'd1,
        ST_X_ONLY    = 3'd2,
        ST_KEEP      = 3'd3,
        ST_INVALID   = 3'd4,
        ST_ZERO_SPAN = 3'd5
    } status_t;

    // Sideband that travels with every transaction through the back end.
    typedef struct packed {
        status_t status;
        logic    special;   // result is forced to zero
    } meta_t;

    localparam int META_W = $bits(meta_t);

    localparam logic [3:0] MASK_ALL      = 4'b1111;
    localparam logic [3:0] MASK_LEFT_COL = 4'b0101;
    localparam logic [3:0] MASK_RIGHT_COL = 4'b1010;
    localparam logic [3:0] MASK_LOW_ROW  = 4'b0011;
    localparam logic [3:0] MASK_UP_ROW   = 4'b1100;
    localparam logic [3:0] MASK_LL       = 4'b0001;
    localparam logic [3:0] MASK_LR       = 4'b0010;
    localparam logic [3:0] MASK_UL       = 4'b0100;
    localparam logic [3:0] MASK_UR       = 4'b1000;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

endpackage

>>> rtl/core/mesh_bilinear_interpolator.sv
// ----------------------------------------------------------------------------
// mesh_bilinear_interpolator
// Bilinear / linear corner interpolation in signed fixed point, streamed.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while s_tready is high and
// returns one result per transaction, in order. The divider resolves one
// quotient bit per pipeline stage over VALUE_WIDTH + 1 stages. Around it
// sit four multiply stages, two divider setup stages and the output register.
// A front end decodes the neighbour mask and maps every mode onto one
// bilinear form; a four-entry queue lets it keep accepting while the back end
// is held by m_tready. Keep-existing and invalid masks and zero spans return
// zero with the matching status; all other results are rounded to nearest,
// ties away from zero, and saturated to the signed VALUE_WIDTH range.
// ----------------------------------------------------------------------------
`include "mesh_bilinear_interpolator_assert.svh"

module mesh_bilinear_interpolator #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // x_low, x_high, y_low, y_high, value_ll, value_lr, value_ul, value_ur,
    // target_x, target_y (low to high), zero padded to whole bytes.
    input  logic [((10*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    // present_mask.
    input  logic [3:0] s_tuser,

    output logic m_tvalid,
    input  logic m_tready,
    // interp_value, zero padded to whole bytes.
    output logic [((VALUE_WIDTH+FRAC_BITS*0+7)/8)*8-1:0] m_tdata,
    // status.
    output logic [2:0] m_tuser
);

    localparam int W  = VALUE_WIDTH;
    localparam int EW = mbi_pkg::META_W + 4*W + 6*(W+1);
    localparam int OUT_TW = ((VALUE_WIDTH+FRAC_BITS*0+7)/8)*8;

    // The fixed-point scale cancels in N / D, so FRAC_BITS shapes no logic.

    logic [EW-1:0] front_entry, queue_entry;
    logic          q_full, q_empty, q_pop, push;
    logic          back_adv;

    mbi_front #(.W(W)) u_front (
        .present_mask (s_tuser),
        .x_low        (s_tdata[0*W +: W]),
        .x_high       (s_tdata[1*W +: W]),
        .y_low        (s_tdata[2*W +: W]),
        .y_high       (s_tdata[3*W +: W]),
        .value_ll     (s_tdata[4*W +: W]),
        .value_lr     (s_tdata[5*W +: W]),
        .value_ul     (s_tdata[6*W +: W]),
        .value_ur     (s_tdata[7*W +: W]),
        .target_x     (s_tdata[8*W +: W]),
        .target_y     (s_tdata[9*W +: W]),
        .entry        (front_entry)
    );

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    // The whole back end moves as one pipeline; it holds only while a
    // finished result waits at the output register.
    assign back_adv = !m_tvalid || m_tready;
    assign q_pop    = back_adv && !q_empty;

    mbi_fifo #(.DW(EW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_entry),
        .pop       (q_pop),
        .pop_data  (queue_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    logic                  mul_valid;
    mbi_pkg::meta_t        mul_meta;
    logic signed [3*W+3:0] mul_n;
    logic signed [2*W+1:0] mul_d;

    mbi_mul #(.W(W)) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (back_adv),
        .in_valid  (q_pop),
        .entry     (queue_entry),
        .out_valid (mul_valid),
        .out_meta  (mul_meta),
        .out_n     (mul_n),
        .out_d     (mul_d)
    );

    logic           div_valid;
    mbi_pkg::meta_t div_meta;
    logic [W-1:0]   div_value;

    mbi_div #(.W(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (back_adv),
        .in_valid  (mul_valid),
        .in_meta   (mul_meta),
        .in_n      (mul_n),
        .in_d      (mul_d),
        .out_valid (div_valid),
        .out_meta  (div_meta),
        .out_value (div_value)
    );

    // Output register: loads whenever the pipeline advances.
    logic              out_valid_reg;
    logic [W-1:0]      out_value_reg;
    mbi_pkg::status_t  out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (back_adv) begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (back_adv) begin
            out_value_reg  <= div_value;
            out_status_reg <= div_meta.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_value_reg);
    assign m_tuser  = out_status_reg;

    // Special statuses always carry a zero value.
    `MBI_ASSERT_NOW(a_special_zero, aclk, aresetn,
        m_tvalid && (m_tuser == mbi_pkg::ST_KEEP || m_tuser == mbi_pkg::ST_INVALID ||
        m_tuser == mbi_pkg::ST_ZERO_SPAN), m_tdata == '0)
    // A transaction pushed while the back end is held leaves the queue
    // holding data in the next cycle.
    `MBI_ASSERT_NEXT(a_queue_fill, aclk, aresetn,
        s_tready && !q_empty && !back_adv && s_tvalid, !q_empty)

endmodule

>>> rtl/core/mbi_front.sv
// ----------------------------------------------------------------------------
// mbi_front
// Decodes the neighbour mask and maps every mode onto one bilinear form.
// ----------------------------------------------------------------------------
module mbi_front #(
    parameter int W = 32
) (
    input  logic [3:0]          present_mask,
    input  logic signed [W-1:0] x_low,
    input  logic signed [W-1:0] x_high,
    input  logic signed [W-1:0] y_low,
    input  logic signed [W-1:0] y_high,
    input  logic signed [W-1:0] value_ll,
    input  logic signed [W-1:0] value_lr,
    input  logic signed [W-1:0] value_ul,
    input  logic signed [W-1:0] value_ur,
    input  logic signed [W-1:0] target_x,
    input  logic signed [W-1:0] target_y,
    output logic [mbi_pkg::META_W+4*W+6*(W+1)-1:0] entry
);

    logic signed [W:0] xl, xh, yl, yh, tx, ty;
    logic signed [W:0] dxh_f, dxl_f, dyh_f, dyl_f, sx_f, sy_f;
    logic signed [W:0] dxh, dxl, dyh, dyl, sx, sy;
    logic signed [W-1:0] vll, vlr, vul, vur;
    mbi_pkg::meta_t meta;
    mbi_pkg::status_t mode;

    assign xl = {x_low[W-1], x_low};
    assign xh = {x_high[W-1], x_high};
    assign yl = {y_low[W-1], y_low};
    assign yh = {y_high[W-1], y_high};
    assign tx = {target_x[W-1], target_x};
    assign ty = {target_y[W-1], target_y};

    assign dxh_f = xh - tx;
    assign dxl_f = tx - xl;
    assign dyh_f = yh - ty;
    assign dyl_f = ty - yl;
    assign sx_f  = xh - xl;
    assign sy_f  = yh - yl;

    // Linear modes reuse the bilinear datapath: the unused axis gets a unit
    // weight on one side and a unit span, so N and D reduce to the 1-D form.
    always_comb begin
        vll  = value_ll;
        vlr  = value_lr;
        vul  = value_ul;
        vur  = value_ur;
        dxh  = dxh_f;
        dxl  = dxl_f;
        dyh  = dyh_f;
        dyl  = dyl_f;
        sx   = sx_f;
        sy   = sy_f;
        mode = mbi_pkg::ST_INVALID;
        unique case (present_mask)
            mbi_pkg::MASK_ALL: begin
                mode = mbi_pkg::ST_BILINEAR;
            end
            mbi_pkg::MASK_LEFT_COL, mbi_pkg::MASK_RIGHT_COL: begin
                mode = mbi_pkg::ST_Y_ONLY;
                vll  = (present_mask == mbi_pkg::MASK_LEFT_COL) ? value_ll : value_lr;
                vul  = (present_mask == mbi_pkg::MASK_LEFT_COL) ? value_ul : value_ur;
                vlr  = '0;
                vur  = '0;
                dxh  = (W+1)'(1);
                dxl  = '0;
                sx   = (W+1)'(1);
            end
            mbi_pkg::MASK_LOW_ROW, mbi_pkg::MASK_UP_ROW: begin
                mode = mbi_pkg::ST_X_ONLY;
                vll  = (present_mask == mbi_pkg::MASK_LOW_ROW) ? value_ll : value_ul;
                vlr  = (present_mask == mbi_pkg::MASK_LOW_ROW) ? value_lr : value_ur;
                vul  = '0;
                vur  = '0;
                dyh  = (W+1)'(1);
                dyl  = '0;
                sy   = (W+1)'(1);
            end
            mbi_pkg::MASK_LL, mbi_pkg::MASK_LR, mbi_pkg::MASK_UL, mbi_pkg::MASK_UR: begin
                mode = mbi_pkg::ST_KEEP;
            end
            default: begin
                mode = mbi_pkg::ST_INVALID;
            end
        endcase
    end

    always_comb begin
        meta.status  = mode;
        meta.special = 1'b1;
        if (mode == mbi_pkg::ST_BILINEAR || mode == mbi_pkg::ST_Y_ONLY ||
            mode == mbi_pkg::ST_X_ONLY) begin
            if (sx == '0 || sy == '0) begin
                meta.status = mbi_pkg::ST_ZERO_SPAN;
            end else begin
                meta.special = 1'b0;
            end
        end
    end

    assign entry = {meta, vll, vlr, vul, vur, dxh, dxl, dyh, dyl, sx, sy};

endmodule

>>> rtl/core/mbi_fifo.sv
// ----------------------------------------------------------------------------
// mbi_fifo
// Short queue between the classifying front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module mbi_fifo #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] pop_data,
    output logic          full,
    output logic          empty
);

    logic [DW-1:0] mem_reg [0:mbi_pkg::FIFO_DEPTH-1];
    logic [mbi_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mbi_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mbi_pkg::FIFO_PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (mbi_pkg::FIFO_PTR_W+1)'(mbi_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (mbi_pkg::FIFO_PTR_W+1)'(push)
                    - (mbi_pkg::FIFO_PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/mbi_mul.sv
// ----------------------------------------------------------------------------
// mbi_mul
// Four-stage product pipeline forming the numerator N and the span product D.
// ----------------------------------------------------------------------------
module mbi_mul #(
    parameter int W = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  logic in_valid,
    input  logic [mbi_pkg::META_W+4*W+6*(W+1)-1:0] entry,
    output logic out_valid,
    output mbi_pkg::meta_t out_meta,
    output logic signed [3*W+3:0] out_n,
    output logic signed [2*W+1:0] out_d
);

    localparam int PW = 2*W+1;
    localparam int AWID = 2*W+2;
    localparam int L = W+1;
    localparam int NW = 3*W+4;

    mbi_pkg::meta_t meta_in;
    logic signed [W-1:0] vll, vlr, vul, vur;
    logic signed [W:0]   dxh, dxl, dyh, dyl, sx, sy;

    assign {meta_in, vll, vlr, vul, vur, dxh, dxl, dyh, dyl, sx, sy} = entry;

    logic [3:0]     vld_reg;
    mbi_pkg::meta_t meta_reg [0:3];

    // Stage 1: corner products along x and the span product.
    logic signed [PW-1:0]   pll_reg, plr_reg, pul_reg, pur_reg;
    logic signed [AWID-1:0] d1_reg;
    logic signed [W:0]      dyh1_reg, dyl1_reg;
    // Stage 2: row sums.
    logic signed [AWID-1:0] a_reg, b_reg, d2_reg;
    logic signed [W:0]      dyh2_reg, dyl2_reg;
    // Stage 3: row sums times y weights, split into low and high halves.
    logic signed [2*W+2:0]  pla_reg, plb_reg;
    logic signed [2*W+1:0]  pha_reg, phb_reg, d3_reg;
    // Stage 4: recombined numerator.
    logic signed [NW-1:0]   n4_reg;
    logic signed [AWID-1:0] d4_reg;

    logic signed [W+1:0] a_lo, b_lo;
    logic signed [W:0]   a_hi, b_hi;
    logic signed [NW-1:0] hsum, lsum;

    assign a_lo = $signed({1'b0, a_reg[L-1:0]});
    assign b_lo = $signed({1'b0, b_reg[L-1:0]});
    assign a_hi = a_reg[AWID-1:L];
    assign b_hi = b_reg[AWID-1:L];
    assign hsum = NW'(pha_reg) + NW'(phb_reg);
    assign lsum = NW'(pla_reg) + NW'(plb_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            meta_reg[0] <= meta_in;
            meta_reg[1] <= meta_reg[0];
            meta_reg[2] <= meta_reg[1];
            meta_reg[3] <= meta_reg[2];

            pll_reg  <= vll * dxh;
            plr_reg  <= vlr * dxl;
            pul_reg  <= vul * dxh;
            pur_reg  <= vur * dxl;
            d1_reg   <= sx * sy;
            dyh1_reg <= dyh;
            dyl1_reg <= dyl;

            a_reg    <= AWID'(pll_reg) + AWID'(plr_reg);
            b_reg    <= AWID'(pul_reg) + AWID'(pur_reg);
            d2_reg   <= d1_reg;
            dyh2_reg <= dyh1_reg;
            dyl2_reg <= dyl1_reg;

            pla_reg  <= a_lo * dyh2_reg;
            plb_reg  <= b_lo * dyl2_reg;
            pha_reg  <= a_hi * dyh2_reg;
            phb_reg  <= b_hi * dyl2_reg;
            d3_reg   <= d2_reg;

            n4_reg   <= (hsum <<< L) + lsum;
            d4_reg   <= d3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_meta  = meta_reg[3];
    assign out_n     = n4_reg;
    assign out_d     = d4_reg;

endmodule

>>> rtl/core/mbi_div.sv
// ----------------------------------------------------------------------------
// mbi_div
// Rounded division N / D, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module mbi_div #(
    parameter int W = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  logic in_valid,
    input  mbi_pkg::meta_t in_meta,
    input  logic signed [3*W+3:0] in_n,
    input  logic signed [2*W+1:0] in_d,
    output logic out_valid,
    output mbi_pkg::meta_t out_meta,
    output logic [W-1:0] out_value
);

    localparam int NW = 3*W+4;
    localparam int DW = 2*W+2;
    localparam int AW = 3*W+5;
    localparam int QW = W+1;

    // Magnitudes: the quotient (2|N|+|D|) / (2|D|) rounds half away from zero.
    logic [NW-1:0] abs_n;
    logic [DW-1:0] abs_d;
    assign abs_n = in_n[NW-1] ? NW'(NW'(0) - in_n) : in_n;
    assign abs_d = in_d[DW-1] ? DW'(DW'(0) - in_d) : in_d;

    logic           v5_reg, s5_reg;
    mbi_pkg::meta_t m5_reg;
    logic [AW-1:0]  an5_reg, ad5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m5_reg  <= in_meta;
            s5_reg  <= in_n[NW-1] ^ in_d[DW-1];
            an5_reg <= (AW'(abs_n) << 1) + AW'(abs_d);
            ad5_reg <= AW'(abs_d) << 1;
        end
    end

    logic           vld_reg  [0:QW];
    logic           sgn_reg  [0:QW];
    logic           ovf_reg  [0:QW];
    mbi_pkg::meta_t meta_reg [0:QW];
    logic [AW-1:0]  rem_reg  [0:QW];
    logic [AW-1:0]  div_reg  [0:QW];
    logic [QW-1:0]  q_reg    [0:QW];

    // Entry stage: a quotient wider than QW bits is flagged and saturates unless the result is special.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sgn_reg[0]  <= s5_reg;
            ovf_reg[0]  <= (an5_reg >= (ad5_reg << QW));
            meta_reg[0] <= m5_reg;
            rem_reg[0]  <= an5_reg;
            div_reg[0]  <= ad5_reg;
            q_reg[0]    <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int B = QW - 1 - k;
        logic [AW-1:0] trial;
        logic          ge;
        assign trial = div_reg[k] << B;
        assign ge    = (rem_reg[k] >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sgn_reg[k+1]  <= sgn_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                meta_reg[k+1] <= meta_reg[k];
                div_reg[k+1]  <= div_reg[k];
                rem_reg[k+1]  <= ge ? rem_reg[k] - trial : rem_reg[k];
                q_reg[k+1]    <= q_reg[k] | (QW'(ge) << B);
            end
        end
    end

    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

    logic [QW-1:0] q_mag, q_neg;
    logic          pos_over, neg_over;

    assign q_mag    = q_reg[QW];
    assign q_neg    = QW'(0) - q_mag;
    assign pos_over = q_mag > QW'(MAX_POS);
    assign neg_over = q_mag > (QW'(1) << (W-1));

    always_comb begin
        priority if (meta_reg[QW].special) begin
            out_value = '0;
        end else if (sgn_reg[QW]) begin
            out_value = (ovf_reg[QW] || neg_over) ? MIN_NEG : q_neg[W-1:0];
        end else begin
            out_value = (ovf_reg[QW] || pos_over) ? MAX_POS : q_mag[W-1:0];
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_meta  = meta_reg[QW];

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for mesh_bilinear_interpolator
// Drives corner boxes through the stream input, predicts each value and
// status with exact wide arithmetic and checks the results in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam int IN_W = ((10*VW+7)/8)*8;
    localparam int OUT_W = ((VW+7)/8)*8;
    localparam int WATCHDOG = 20000;

    typedef logic signed [VW-1:0] val_t;

    // One input transaction.
    typedef struct {
        logic [3:0] mask;
        val_t       xl, xh, yl, yh, vll, vlr, vul, vur, tx, ty;
    } box_t;

    // One result transaction.
    typedef struct {
        val_t             value;
        mbi_pkg::status_t status;
    } interp_t;

    // Wide signed arithmetic: products of three 33-bit terms fit easily in 200 bits.
    typedef logic signed [199:0] wide_t;

    // Rounds N / D to nearest, ties away from zero, then saturates.
    function automatic val_t round_sat(wide_t n, wide_t d);
        wide_t an, ad, q;
        wide_t vmax, vmin;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2*an + ad) / (2*ad);
        if ((n < 0) != (d < 0)) q = -q;
        vmax = (wide_t'(1) <<< (VW-1)) - 1;
        vmin = -(wide_t'(1) <<< (VW-1));
        if (q > vmax) return val_t'(vmax);
        if (q < vmin) return val_t'(vmin);
        return val_t'(q);
    endfunction

    // Linear weighted sum a*(hi - t) + b*(t - lo).
    function automatic wide_t lerp_sum(val_t a, val_t b, val_t lo, val_t hi, val_t t);
        return wide_t'(a) * (wide_t'(hi) - wide_t'(t)) + wide_t'(b) * (wide_t'(t) - wide_t'(lo));
    endfunction

    function automatic interp_t interpolate(box_t b);
        interp_t r;
        wide_t n, d;
        wide_t dxl, dxh, dyl, dyh;
        dxl = wide_t'(b.tx) - wide_t'(b.xl);
        dxh = wide_t'(b.xh) - wide_t'(b.tx);
        dyl = wide_t'(b.ty) - wide_t'(b.yl);
        dyh = wide_t'(b.yh) - wide_t'(b.ty);
        r.value = '0;
        n = 0;
        d = 0;
        case (b.mask)
            mbi_pkg::MASK_ALL: begin
                n = wide_t'(b.vll)*dxh*dyh + wide_t'(b.vlr)*dxl*dyh
                  + wide_t'(b.vul)*dxh*dyl + wide_t'(b.vur)*dxl*dyl;
                d = (wide_t'(b.xh) - wide_t'(b.xl)) * (wide_t'(b.yh) - wide_t'(b.yl));
                r.status = mbi_pkg::ST_BILINEAR;
            end
            mbi_pkg::MASK_LEFT_COL, mbi_pkg::MASK_RIGHT_COL: begin
                n = (b.mask == mbi_pkg::MASK_LEFT_COL)
                  ? lerp_sum(b.vll, b.vul, b.yl, b.yh, b.ty)
                  : lerp_sum(b.vlr, b.vur, b.yl, b.yh, b.ty);
                d = wide_t'(b.yh) - wide_t'(b.yl);
                r.status = mbi_pkg::ST_Y_ONLY;
            end
            mbi_pkg::MASK_LOW_ROW, mbi_pkg::MASK_UP_ROW: begin
                n = (b.mask == mbi_pkg::MASK_LOW_ROW)
                  ? lerp_sum(b.vll, b.vlr, b.xl, b.xh, b.tx)
                  : lerp_sum(b.vul, b.vur, b.xl, b.xh, b.tx);
                d = wide_t'(b.xh) - wide_t'(b.xl);
                r.status = mbi_pkg::ST_X_ONLY;
            end
            mbi_pkg::MASK_LL, mbi_pkg::MASK_LR, mbi_pkg::MASK_UL, mbi_pkg::MASK_UR: begin
                r.status = mbi_pkg::ST_KEEP;
                return r;
            end
            default: begin
                r.status = mbi_pkg::ST_INVALID;
                return r;
            end
        endcase
        if (d == 0) begin
            r.status = mbi_pkg::ST_ZERO_SPAN;
            return r;
        end
        r.value = round_sat(n, d);
        return r;
    endfunction

    // Holds the expected results in order and compares what comes out.
    class interp_scoreboard;
        interp_t pending[$];
        int      mismatches = 0;

        function void note_box(box_t b);
            pending.push_back(interpolate(b));
        endfunction

        function void check_result(val_t value, mbi_pkg::status_t status);
            interp_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h status=%0d", value, status);
                return;
            end
            e = pending.pop_front();
            if (e.value !== value || e.status !== status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                             e.value, e.status, value, status);
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [3:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [2:0]       m_tuser;

    interp_scoreboard scoreboard = new();
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               idle_cycles = 0;
    int               boxes_sent = 0;
    int               results_seen = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    mesh_bilinear_interpolator #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Result side: sample accepted transactions and choose the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            scoreboard.check_result(val_t'(m_tdata[VW-1:0]), mbi_pkg::status_t'(m_tuser));
        end
        if (aresetn && (s_tvalid && s_tready || m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        m_tready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Sends one box, with a random gap before it, and waits for acceptance.
    task automatic send_box(box_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.mask;
        s_tdata  <= IN_W'({b.ty, b.tx, b.vur, b.vul, b.vlr, b.vll, b.yh, b.yl, b.xh, b.xl});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        scoreboard.note_box(b);
        boxes_sent++;
    endtask

    // Edge values are favored so saturation and extreme spans come up often.
    function automatic val_t pick_value(int unsigned spread);
        case ($urandom_range(9))
            0: return val_t'(32'h7fffffff);
            1: return val_t'(32'h80000000);
            2: return val_t'($urandom);
            default: return val_t'($signed($urandom_range(2*spread)) - $signed(spread));
        endcase
    endfunction

    function automatic box_t random_box();
        box_t b;
        int unsigned spread;
        spread = ($urandom_range(3) == 0) ? 32'h7fffffff : 32'h0010_0000;
        case ($urandom_range(9))
            0, 1, 2, 3: b.mask = mbi_pkg::MASK_ALL;
            4: b.mask = mbi_pkg::MASK_LEFT_COL;
            5: b.mask = mbi_pkg::MASK_RIGHT_COL;
            6: b.mask = mbi_pkg::MASK_LOW_ROW;
            7: b.mask = mbi_pkg::MASK_UP_ROW;
            default: b.mask = 4'($urandom_range(15));
        endcase
        b.xl = pick_value(spread);
        b.xh = ($urandom_range(15) == 0) ? b.xl : pick_value(spread);
        b.yl = pick_value(spread);
        b.yh = ($urandom_range(15) == 0) ? b.yl : pick_value(spread);
        b.vll = pick_value(spread);
        b.vlr = pick_value(spread);
        b.vul = pick_value(spread);
        b.vur = pick_value(spread);
        b.tx = pick_value(spread);
        b.ty = pick_value(spread);
        return b;
    endfunction

    initial begin
        box_t b;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: every mask, a small box around the target, zero and reversed
        // spans, extremes in all fields but vul, and a target far outside the box.
        for (int m = 0; m < 16; m++) begin
            b.mask = 4'(m);
            b.xl = 0;  b.xh = val_t'(32'h0001_0000);
            b.yl = 0;  b.yh = val_t'(32'h0002_0000);
            b.vll = val_t'(32'h0001_0000); b.vlr = val_t'(32'h0003_0000);
            b.vul = val_t'(-32'sh0002_0000); b.vur = val_t'(32'h0000_8000);
            b.tx = val_t'(32'h0000_4000); b.ty = val_t'(32'h0001_8000);
            send_box(b);
        end
        b.mask = mbi_pkg::MASK_ALL; b.xh = b.xl;
        send_box(b);
        b.mask = mbi_pkg::MASK_LEFT_COL; b.yh = b.yl; b.xh = val_t'(32'h0001_0000);
        send_box(b);
        b.mask = mbi_pkg::MASK_LOW_ROW; b.xl = val_t'(32'h0005_0000);
        b.xh = val_t'(32'h0001_0000);
        send_box(b);
        b.mask = mbi_pkg::MASK_ALL; b.xl = val_t'(32'h80000000); b.xh = val_t'(32'h7fffffff);
        b.yl = val_t'(32'h7fffffff); b.yh = val_t'(32'h80000000);
        b.vll = val_t'(32'h7fffffff); b.vlr = val_t'(32'h80000000);
        b.vul = val_t'(32'hffffffff); b.vur = val_t'(32'h7fffffff);
        b.tx = val_t'(32'h7fffffff); b.ty = val_t'(32'h80000000);
        send_box(b);
        b.mask = mbi_pkg::MASK_UP_ROW; b.xl = 0; b.xh = 1; b.tx = val_t'(32'h7fffffff);
        send_box(b);
        // Tie case: exact half rounds away from zero.
        b.mask = mbi_pkg::MASK_LOW_ROW; b.xl = 0; b.xh = 2; b.tx = 1;
        b.vll = -1; b.vlr = -2;
        send_box(b);

        // Random part over the four idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 16 : 59) : 0;
            stall_pct     = (phase == 2 || phase == 3) ? ((phase == 3) ? 16 : 59) : 0;
            for (int i = 0; i < 100; i++) send_box(random_box());
        end
        s_tvalid <= 1'b0;

        while (scoreboard.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Sent %0d corner boxes across four handshake pacing phases.", boxes_sent);
        $display("Checked %0d interpolated results covering all sixteen masks.", results_seen);
        if (scoreboard.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches counted", scoreboard.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
